FILE: hdl/ntc_pkg.sv
package ntc_pkg;

  // Residue arithmetic over p = 5*2^25 + 1.
  localparam int DW = 28;
  localparam logic [DW-1:0] MODULUS = 28'(5 * (1 << 25) + 1);
  localparam logic [DW-1:0] FWD_ROOT = 28'd243;
  localparam logic [DW-1:0] INV_ROOT = 28'd114609789;
  localparam int ROOT_LOG = 25;
  localparam int SQ_W = $clog2(ROOT_LOG + 1);

  // Barrett constant floor(2^56 / p) for the modular multiplier.
  localparam logic [63:0] BARRETT_MU = (64'd1 << (2 * DW)) / 64'(MODULUS);
  localparam int MU_W = DW + 1;

  // MUL_LAT is the modular multiplier's latency from issue to result.
  localparam int MUL_LAT = 4;
  localparam int WT_W = 2;

  localparam int MAX_LEN_DEF = 64;
  localparam int IDX_W = 6;
  localparam int LOG_SIZE_W = 3;
  localparam int MODE_W = 2;
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 3;

  localparam logic [CFG_IW-1:0] CFG_LOG_SIZE = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_MODE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_CONV = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_TSETUP,
    ST_SQ_ISSUE,
    ST_SQ_TAKE,
    ST_WAIT,
    ST_BF_RD,
    ST_BF_MV,
    ST_BF_MW,
    ST_BF_WR1,
    ST_BF_WR2,
    ST_PW_RD,
    ST_PW_MUL,
    ST_PW_WR,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_SET,
    ST_OUT_HOLD
  } state_t;

  typedef enum logic [1:0] {
    PASS_FWD_A,
    PASS_FWD_B,
    PASS_PROD,
    PASS_INV_A
  } pass_t;

endpackage

FILE: hdl/ntt_cyclic_convolution.sv
// After the last word of a run the block runs its transforms, each stage a
// twiddle step and then its butterflies, with a pointwise product between the
// forward and inverse passes in convolution mode, and then scales and emits
// the result words one at a time. Throughput: one input word per cycle while
// loading; no new run is taken until the last result word has been taken.
// Reset (synchronous, active low) clears the control state, sets log_size
// to 6 and mode to convolution; the stores hold no defined contents.
module ntt_cyclic_convolution #(
  parameter int MAX_LEN = ntc_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ntc_pkg::DW-1:0]     in_first_value,
  input  logic [ntc_pkg::DW-1:0]     in_second_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ntc_pkg::DW-1:0]     out_result_value,
  output logic [ntc_pkg::IDX_W-1:0]  out_result_index,
  output logic                       out_is_last,
  input  logic                       cfg_we,
  input  logic [ntc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ntc_pkg::CFG_DW-1:0] cfg_data
);
  import ntc_pkg::*;

  // LOGK is the largest transform size exponent that fits the stores.
  localparam int LOGK = $clog2(MAX_LEN + 1) - 1;
  localparam int AW   = $clog2(MAX_LEN);
  localparam int CW   = LOGK + 1;
  localparam int LGW  = $clog2(LOGK + 1);

  // Both operand stores: one write port, two registered read ports each.
  logic [DW-1:0] mem_a [MAX_LEN];
  logic [DW-1:0] mem_b [MAX_LEN];
  logic          wr_a_en, wr_b_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_a_data, wr_b_data;
  logic [AW-1:0] rd_addr0, rd_addr1;
  logic [DW-1:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;

  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      mem_a[wr_addr] <= wr_a_data;
    end
    rd_a0_r <= mem_a[rd_addr0];
    rd_a1_r <= mem_a[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (wr_b_en) begin
      mem_b[wr_addr] <= wr_b_data;
    end
    rd_b0_r <= mem_b[rd_addr0];
    rd_b1_r <= mem_b[rd_addr1];
  end

  // The one modular multiplier shared by every pass.
  logic [DW-1:0] mm_a, mm_b, mm_res;

  ntc_mulmod u_mulmod (
    .clk   (clk),
    .a_i   (mm_a),
    .b_i   (mm_b),
    .res_o (mm_res)
  );

  // Control state.
  state_t               state_r, state_nxt, ret_r, ret_nxt;
  pass_t                pass_r, pass_nxt;
  logic [LOG_SIZE_W-1:0] log_size_r;
  logic [MODE_W-1:0]    mode_r;
  logic [CW-1:0]        lc_r, lc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WT_W-1:0]      wt_r, wt_nxt;

  // Working registers.
  logic [LGW-1:0]       lg_r, lg_nxt, hs_r, hs_nxt;
  logic                 conv_r, conv_nxt, rev_r, rev_nxt, orev_r, orev_nxt;
  logic [DW-1:0]        scale_r, scale_nxt, step_r, step_nxt, w_r, w_nxt;
  logic [DW-1:0]        u_r, u_nxt, diff_r, diff_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic [CW-1:0]        base_r, base_nxt, j_r, j_nxt, i_r, i_nxt;
  logic [DW-1:0]        out_value_r, out_value_nxt;
  logic [CW-1:0]        out_pos_r, out_pos_nxt;
  logic                 out_last_r, out_last_nxt;

  // Derived values.
  logic [LGW-1:0]       lg_eff;
  logic [CW-1:0]        n_eff, n_r, half, u_idx, v_idx;
  logic [DW-1:0]        ninv_eff, in_a_red, in_b_red, bf_sum, bf_diff;
  logic [DW:0]          sum_wide, diff_wide;
  logic                 sel_b, inv_pass;
  logic [AW-1:0]        u_addr, v_addr;
  logic [CW+IDX_W-1:0]  pos_ext;

  function automatic logic [DW-1:0] reduce(input logic [DW-1:0] x);
    reduce = (x >= MODULUS) ? x - MODULUS : x;
  endfunction

  // Bit-reversed index over the lg low bits.
  function automatic logic [LOGK-1:0] bitrev(input logic [LOGK-1:0] x,
                                             input logic [LGW-1:0] lg);
    logic [LOGK-1:0] r;
    for (int b = 0; b < LOGK; b++) begin
      r[b] = x[LOGK-1-b];
    end
    bitrev = r >> (LGW'(LOGK) - lg);
  endfunction

  function automatic logic [AW-1:0] map_addr(input logic [CW-1:0] x,
                                             input logic rev,
                                             input logic [LGW-1:0] lg);
    map_addr = rev ? AW'(bitrev(x[LOGK-1:0], lg)) : AW'(x[LOGK-1:0]);
  endfunction

  always_comb begin
    lg_eff   = (int'(log_size_r) < LOGK) ? LGW'(log_size_r) : LGW'(LOGK);
    n_eff    = CW'(1) << lg_eff;
    n_r      = CW'(1) << lg_r;
    // The inverse of 2^k is p - (p - 1) / 2^k, since 2^25 divides p - 1.
    ninv_eff = MODULUS - ((MODULUS - 28'd1) >> lg_eff);
    half     = CW'(1) << hs_r;
    u_idx    = base_r + j_r;
    v_idx    = u_idx + half;
    u_addr   = map_addr(u_idx, rev_r, lg_r);
    v_addr   = map_addr(v_idx, rev_r, lg_r);
    sel_b    = (pass_r == PASS_FWD_B);
    inv_pass = (pass_r == PASS_INV_A);
    in_a_red = reduce(in_first_value);
    in_b_red = reduce(in_second_value);
    // Butterfly: mm_res holds v * w in the first write cycle.
    sum_wide  = {1'b0, u_r} + {1'b0, mm_res};
    bf_sum    = (sum_wide >= {1'b0, MODULUS}) ? DW'(sum_wide - {1'b0, MODULUS})
                                              : DW'(sum_wide);
    diff_wide = (u_r >= mm_res) ? {1'b0, u_r} - {1'b0, mm_res}
                                : {1'b0, u_r} + {1'b0, MODULUS} - {1'b0, mm_res};
    bf_diff   = DW'(diff_wide);
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pass_nxt      = pass_r;
    lc_nxt        = lc_r;
    out_valid_nxt = out_valid_r;
    wt_nxt        = wt_r;
    lg_nxt        = lg_r;
    hs_nxt        = hs_r;
    conv_nxt      = conv_r;
    rev_nxt       = rev_r;
    orev_nxt      = orev_r;
    scale_nxt     = scale_r;
    step_nxt      = step_r;
    w_nxt         = w_r;
    u_nxt         = u_r;
    diff_nxt      = diff_r;
    sq_nxt        = sq_r;
    base_nxt      = base_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    wr_a_en       = 1'b0;
    wr_b_en       = 1'b0;
    wr_addr       = u_addr;
    wr_a_data     = bf_sum;
    wr_b_data     = bf_sum;
    rd_addr0      = u_addr;
    rd_addr1      = v_addr;
    mm_a          = w_r;
    mm_b          = step_r;

    case (state_r)
      ST_LOAD: begin
        wr_addr   = AW'(lc_r[LOGK-1:0]);
        wr_a_data = in_a_red;
        wr_b_data = in_b_red;
        if (in_valid) begin
          wr_a_en = 1'b1;
          wr_b_en = 1'b1;
          if (lc_r + CW'(1) >= n_eff) begin
            // Last word of the run: latch the size and plan the passes.
            lc_nxt    = '0;
            lg_nxt    = lg_eff;
            hs_nxt    = '0;
            rev_nxt   = 1'b1;
            state_nxt = ST_TSETUP;
            case (mode_r)
              MODE_CONV: begin
                conv_nxt  = 1'b1;
                pass_nxt  = PASS_FWD_A;
                orev_nxt  = 1'b0;
                scale_nxt = ninv_eff;
              end
              MODE_FWD: begin
                conv_nxt  = 1'b0;
                pass_nxt  = PASS_FWD_A;
                orev_nxt  = 1'b1;
                scale_nxt = 28'd1;
              end
              default: begin
                conv_nxt  = 1'b0;
                pass_nxt  = PASS_INV_A;
                orev_nxt  = 1'b1;
                scale_nxt = ninv_eff;
              end
            endcase
          end else begin
            lc_nxt = lc_r + CW'(1);
          end
        end
      end

      ST_TSETUP: begin
        if (hs_r == lg_r) begin
          i_nxt = '0;
          case (pass_r)
            PASS_FWD_A: begin
              if (conv_r) begin
                pass_nxt = PASS_FWD_B;
                hs_nxt   = '0;
              end else begin
                state_nxt = ST_OUT_RD;
              end
            end
            PASS_FWD_B: begin
              pass_nxt  = PASS_PROD;
              state_nxt = ST_PW_RD;
            end
            default: begin
              state_nxt = ST_OUT_RD;
            end
          endcase
        end else begin
          // Twiddle step for this stage: the root squared 24 - hs times.
          step_nxt  = inv_pass ? INV_ROOT : FWD_ROOT;
          sq_nxt    = SQ_W'(ROOT_LOG - 1) - SQ_W'(hs_r);
          state_nxt = ST_SQ_ISSUE;
        end
      end

      ST_SQ_ISSUE: begin
        mm_a      = step_r;
        mm_b      = step_r;
        wt_nxt    = WT_W'(MUL_LAT - 2);
        ret_nxt   = ST_SQ_TAKE;
        state_nxt = ST_WAIT;
      end

      ST_SQ_TAKE: begin
        step_nxt = mm_res;
        sq_nxt   = sq_r - SQ_W'(1);
        if (sq_r == SQ_W'(1)) begin
          base_nxt  = '0;
          j_nxt     = '0;
          w_nxt     = 28'd1;
          state_nxt = ST_BF_RD;
        end else begin
          state_nxt = ST_SQ_ISSUE;
        end
      end

      ST_WAIT: begin
        if (wt_r == '0) begin
          state_nxt = ret_r;
        end else begin
          wt_nxt = wt_r - WT_W'(1);
        end
      end

      ST_BF_RD: begin
        state_nxt = ST_BF_MV;
      end

      ST_BF_MV: begin
        u_nxt     = sel_b ? rd_b0_r : rd_a0_r;
        mm_a      = sel_b ? rd_b1_r : rd_a1_r;
        mm_b      = w_r;
        state_nxt = ST_BF_MW;
      end

      ST_BF_MW: begin
        // Next twiddle w * step, issued in the cycle after the data product.
        wt_nxt    = WT_W'(MUL_LAT - 3);
        ret_nxt   = ST_BF_WR1;
        state_nxt = ST_WAIT;
      end

      ST_BF_WR1: begin
        wr_addr   = u_addr;
        wr_a_data = bf_sum;
        wr_b_data = bf_sum;
        wr_a_en   = !sel_b;
        wr_b_en   = sel_b;
        diff_nxt  = bf_diff;
        state_nxt = ST_BF_WR2;
      end

      ST_BF_WR2: begin
        wr_addr   = v_addr;
        wr_a_data = diff_r;
        wr_b_data = diff_r;
        wr_a_en   = !sel_b;
        wr_b_en   = sel_b;
        if (j_r + CW'(1) == half) begin
          j_nxt = '0;
          w_nxt = 28'd1;
          if (base_r + (half << 1) >= n_r) begin
            hs_nxt    = hs_r + LGW'(1);
            state_nxt = ST_TSETUP;
          end else begin
            base_nxt  = base_r + (half << 1);
            state_nxt = ST_BF_RD;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          w_nxt     = mm_res;
          state_nxt = ST_BF_RD;
        end
      end

      ST_PW_RD: begin
        rd_addr0  = AW'(i_r[LOGK-1:0]);
        state_nxt = ST_PW_MUL;
      end

      ST_PW_MUL: begin
        mm_a      = rd_a0_r;
        mm_b      = rd_b0_r;
        wt_nxt    = WT_W'(MUL_LAT - 2);
        ret_nxt   = ST_PW_WR;
        state_nxt = ST_WAIT;
      end

      ST_PW_WR: begin
        wr_addr   = AW'(i_r[LOGK-1:0]);
        wr_a_data = mm_res;
        wr_a_en   = 1'b1;
        if (i_r + CW'(1) == n_r) begin
          // Spectrum product done; the inverse pass reads it in natural order.
          i_nxt     = '0;
          pass_nxt  = PASS_INV_A;
          rev_nxt   = 1'b0;
          hs_nxt    = '0;
          state_nxt = ST_TSETUP;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_PW_RD;
        end
      end

      ST_OUT_RD: begin
        rd_addr0  = map_addr(i_r, orev_r, lg_r);
        state_nxt = ST_OUT_MUL;
      end

      ST_OUT_MUL: begin
        mm_a      = rd_a0_r;
        mm_b      = scale_r;
        wt_nxt    = WT_W'(MUL_LAT - 2);
        ret_nxt   = ST_OUT_SET;
        state_nxt = ST_WAIT;
      end

      ST_OUT_SET: begin
        out_value_nxt = mm_res;
        out_pos_nxt   = i_r;
        out_last_nxt  = (i_r + CW'(1) == n_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            i_nxt     = '0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ret_r       <= ST_LOAD;
      lc_r        <= '0;
      out_valid_r <= 1'b0;
      wt_r        <= '0;
      log_size_r  <= 3'd6;
      mode_r      <= MODE_CONV;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      lc_r        <= lc_nxt;
      out_valid_r <= out_valid_nxt;
      wt_r        <= wt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG_SIZE: log_size_r <= cfg_data;
          CFG_MODE:     mode_r     <= cfg_data[MODE_W-1:0];
          default:      mode_r     <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_r      <= pass_nxt;
    lg_r        <= lg_nxt;
    hs_r        <= hs_nxt;
    conv_r      <= conv_nxt;
    rev_r       <= rev_nxt;
    orev_r      <= orev_nxt;
    scale_r     <= scale_nxt;
    step_r      <= step_nxt;
    w_r         <= w_nxt;
    u_r         <= u_nxt;
    diff_r      <= diff_nxt;
    sq_r        <= sq_nxt;
    base_r      <= base_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign pos_ext          = {IDX_W'(0), out_pos_r};
  assign in_ready         = (state_r == ST_LOAD);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = pos_ext[IDX_W-1:0];
  assign out_is_last      = out_last_r;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  // The load counter is back at zero whenever the block is not loading.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (lc_r == '0))
    else $error("load count not cleared outside loading");

  // A taken word that is not the last is followed by a gap while the next
  // element is read and scaled.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_is_last) |=> !out_valid)
    else $error("result word repeated");

endmodule

FILE: hdl/ntc_mulmod.sv
module ntc_mulmod (
  input  logic                   clk,
  input  logic [ntc_pkg::DW-1:0] a_i,
  input  logic [ntc_pkg::DW-1:0] b_i,
  output logic [ntc_pkg::DW-1:0] res_o
);
  import ntc_pkg::*;

  // Four-stage Barrett reduction: product, quotient estimate, remainder,
  // final correction. The quotient estimate is at most two below the truth.
  logic [2*DW-1:0]    prod_r;
  logic [2*MU_W-1:0]  t_r;
  logic [DW+1:0]      lo_r;
  logic [DW+1:0]      rem_r;
  logic [DW-1:0]      res_r;
  logic [DW+1:0]      q30;
  logic [DW+1:0]      qp;
  logic [DW+1:0]      p30;

  always_comb begin
    q30 = (DW + 2)'(t_r[2*MU_W-1:MU_W]);
    qp  = (q30 << (DW - 1)) + (q30 << (DW - 3)) + q30;
    p30 = (DW + 2)'(MODULUS);
  end

  always_ff @(posedge clk) begin
    prod_r <= (2 * DW)'(a_i) * (2 * DW)'(b_i);
    t_r    <= (2 * MU_W)'(prod_r[2*DW-1:DW-1]) * (2 * MU_W)'(BARRETT_MU[MU_W-1:0]);
    lo_r   <= prod_r[DW+1:0];
    rem_r  <= lo_r - qp;
    if (rem_r >= (p30 << 1)) begin
      res_r <= DW'(rem_r - (p30 << 1));
    end else if (rem_r >= p30) begin
      res_r <= DW'(rem_r - p30);
    end else begin
      res_r <= DW'(rem_r);
    end
  end

  assign res_o = res_r;

endmodule

FILE: tb/ntc_checker.sv
module ntc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ntc_pkg::DW-1:0]     in_first_value,
  input  logic [ntc_pkg::DW-1:0]     in_second_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ntc_pkg::DW-1:0]     out_result_value,
  input  logic [ntc_pkg::IDX_W-1:0]  out_result_index,
  input  logic                       out_is_last,
  input  logic                       cfg_we,
  input  logic [ntc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ntc_pkg::CFG_DW-1:0] cfg_data,
  output int                         fail_count,
  output int                         words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  localparam int LEN = MAX_LEN_DEF;
  localparam int LOG_MAX = $clog2(LEN);

  typedef logic [DW-1:0] vec_t [LEN];
  typedef struct packed {
    logic [DW-1:0]    value;
    logic [IDX_W-1:0] index;
    logic             last;
  } result_t;

  vec_t                  store_a, store_b;
  int                    loaded;
  logic [LOG_SIZE_W-1:0] log_size;
  logic [MODE_W-1:0]     mode;
  result_t               expected_words[$];

  function automatic logic [DW-1:0] mulm(logic [DW-1:0] x, logic [DW-1:0] y);
    logic [63:0] prod;
    prod = 64'(x) * 64'(y);
    return DW'(prod % 64'(MODULUS));
  endfunction

  function automatic logic [DW-1:0] reduce_once(logic [DW-1:0] x);
    return (x >= MODULUS) ? x - MODULUS : x;
  endfunction

  function automatic vec_t ntt(vec_t v, int lg, bit inverse);
    int n, rev, half;
    logic [DW-1:0] tmp, u, w, step, scale;
    logic [DW:0] sum;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < lg; b++)
        if (i[b]) rev |= 1 << (lg - 1 - b);
      if (i < rev) begin
        tmp = v[i]; v[i] = v[rev]; v[rev] = tmp;
      end
    end
    for (int len = 2; len <= n; len <<= 1) begin
      step = inverse ? INV_ROOT : FWD_ROOT;
      // Square the root of order 2^25 down to a root of order len.
      for (longint t = len; t < (64'd1 << ROOT_LOG); t <<= 1) step = mulm(step, step);
      half = len / 2;
      for (int base = 0; base < n; base += len) begin
        w = 1;
        for (int j = 0; j < half; j++) begin
          u = v[base + j];
          tmp = mulm(v[base + j + half], w);
          sum = u + tmp;
          v[base + j] = (sum >= MODULUS) ? DW'(sum - MODULUS) : DW'(sum);
          v[base + j + half] = (u >= tmp) ? u - tmp : u + MODULUS - tmp;
          w = mulm(w, step);
        end
      end
    end
    if (inverse) begin
      scale = 1;
      for (int k = 0; k < lg; k++)
        scale = scale[0] ? DW'((29'(scale) + 29'(MODULUS)) >> 1) : scale >> 1;
      for (int i = 0; i < n; i++) v[i] = mulm(v[i], scale);
    end
    return v;
  endfunction

  task automatic load_pair(logic [DW-1:0] a, logic [DW-1:0] b);
    int lg, n;
    vec_t xa, xb;
    result_t r;
    lg = (int'(log_size) < LOG_MAX) ? int'(log_size) : LOG_MAX;
    n = 1 << lg;
    if (loaded < LEN) begin
      store_a[loaded] = reduce_once(a);
      store_b[loaded] = reduce_once(b);
    end
    loaded++;
    if (loaded < n) return;
    loaded = 0;
    xa = store_a;
    if (mode == MODE_CONV) begin
      xa = ntt(xa, lg, 1'b0);
      xb = ntt(store_b, lg, 1'b0);
      for (int i = 0; i < n; i++) xa[i] = mulm(xa[i], xb[i]);
      xa = ntt(xa, lg, 1'b1);
    end else if (mode == MODE_FWD) begin
      xa = ntt(xa, lg, 1'b0);
    end else begin
      xa = ntt(xa, lg, 1'b1);
    end
    for (int i = 0; i < n; i++) begin
      r.value = xa[i];
      r.index = IDX_W'(i);
      r.last = (i == n - 1);
      expected_words = {expected_words, r};
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      loaded = 0;
      log_size = LOG_SIZE_W'(6);
      mode = MODE_CONV;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we && cfg_index == CFG_LOG_SIZE) log_size = cfg_data[LOG_SIZE_W-1:0];
      if (cfg_we && cfg_index == CFG_MODE) mode = cfg_data[MODE_W-1:0];
      if (in_valid && in_ready) load_pair(in_first_value, in_second_value);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word value %0d index %0d last %0b", $time,
                   out_result_value, out_result_index, out_is_last);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.value !== out_result_value || e.index !== out_result_index ||
              e.last !== out_is_last) begin
            $display("%0t: mismatch expected value %0d index %0d last %0b, got %0d %0d %0b",
                     $time, e.value, e.index, e.last,
                     out_result_value, out_result_index, out_is_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  // The package names only convolution and forward; the other mode codes live here.
  localparam logic [MODE_W-1:0] MODE_INV = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [DW-1:0] ALL_ONES = '1;
  // Cycles without any accepted word before the run is declared hung. A 64-point
  // convolution produces its first word well inside this limit.
  localparam int HANG_LIMIT = 40000;
  // Quiet time after the last expected word before touching the registers.
  localparam int SETTLE = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DW-1:0] in_first_value = '0;
  logic [DW-1:0] in_second_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DW-1:0] out_result_value;
  logic [IDX_W-1:0] out_result_index;
  logic out_is_last;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int fail_count;
  int words_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ntt_cyclic_convolution u_dut (.*);

  ntc_checker u_checker (.*);

  // The receiver stalls on a fraction of cycles set by the current phase.
  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Watchdog: any accepted word on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Residues with the edges weighted up: zero, p-1, values at or above p that the
  // block reduces on load, and the all-ones pattern so every input bit toggles.
  function automatic logic [DW-1:0] pick_residue();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return MODULUS - 1;
      2: return DW'($urandom_range(int'(MODULUS), int'(ALL_ONES)));
      3: return ALL_ONES;
      default: return DW'($urandom_range(0, int'(MODULUS) - 1));
    endcase
  endfunction

  // Presents one word and returns at the edge that accepts it. Valid stays high
  // afterwards so back-to-back words need only one assignment per edge.
  task automatic send_pair(logic [DW-1:0] a, logic [DW-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_value <= a;
    in_second_value <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Drops valid, waits for every expected word, then lets the block finish any
  // work that produces no words before the registers may change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(int lg, logic [MODE_W-1:0] md);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOG_SIZE;
    cfg_data <= CFG_DW'(lg);
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_data <= CFG_DW'(md);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_pair(pick_residue(), pick_residue());
  endtask

  initial begin
    int lg;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Single-point convolution is the plain modular product.
    set_regs(0, MODE_CONV);
    send_pair('0, '0);
    send_pair(MODULUS - 1, MODULUS - 1);
    send_pair(MODULUS, ALL_ONES);
    send_pair(ALL_ONES, 28'd1);
    settle();
    set_regs(1, MODE_FWD);
    send_pair(MODULUS - 1, '0);
    send_pair(28'd1, ALL_ONES);
    settle();
    set_regs(2, MODE_INV);
    for (int i = 0; i < 4; i++) send_pair(MODULUS - 1 - DW'(i), 28'd5);
    settle();
    // The unused mode code acts as an inverse transform.
    set_regs(2, MODE_SPARE);
    for (int i = 0; i < 4; i++) send_pair(DW'(i + 1), '0);
    settle();
    // Shrink the length mid-run: five words loaded toward eight, then the
    // length drops to four and the next word ends the run on entries 0..3.
    set_regs(3, MODE_CONV);
    for (int i = 0; i < 5; i++) send_pair(DW'(i + 7), DW'(3 * i + 1));
    settle();
    set_regs(2, MODE_CONV);
    send_pair(28'd9, 28'd2);
    settle();

    // Random part, walking through the idle phases. Most runs are short; a few
    // use the full length, including the oversized code that saturates to 64.
    // A run that would go well past the word budget is shortened.
    while (words_sent < 180) begin
      case ((words_sent - 20) * 4 / 160)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      case ($urandom_range(0, 9))
        7, 8: lg = $urandom_range(4, 5);
        9: lg = $urandom_range(6, 7);
        default: lg = $urandom_range(0, 3);
      endcase
      while ((1 << ((lg > 6) ? 6 : lg)) > 185 - words_sent) lg--;
      set_regs(lg, MODE_W'($urandom_range(0, 3)));
      run_random(1 << ((lg > 6) ? 6 : lg));
      settle();
    end

    if (fail_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
